>>> src/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants, types and codes for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int WORD_WIDTH     = 32;
   // decimal digits of 2^WORD_WIDTH-1 (log10(2) ~ 0.30103)
   localparam int NUM_DIGITS     = (WORD_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_WIDTH      = 4 * NUM_DIGITS;
   localparam int BITS_PER_STEP  = 4;
   localparam int NUM_STEPS      = (WORD_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PAD_WIDTH      = NUM_STEPS * BITS_PER_STEP;
   localparam int STEP_CNT_WIDTH = $clog2(NUM_STEPS + 1);
   localparam int LEFT_WIDTH     = $clog2(NUM_DIGITS + 1);

   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_MINUS = 8'd45;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic skip;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic step_done;
      logic top_zero;
      logic last_digit;
      logic negative;
      logic out_free;
   } status_type;

endpackage

>>> src/b2da_dpath.sv
// ----------------------------------------------------------------------------
// b2da_dpath
// Magnitude, shift-add-3 BCD converter, digit counter and output register.
// ----------------------------------------------------------------------------
module b2da_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  b2da_pkg::cmd_type     cmd,
   output b2da_pkg::status_type  status,
   input  logic [31:0]           value,
   input  logic                  is_signed,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_char,
   output logic                  out_last
);
   import b2da_pkg::*;

   logic [PAD_WIDTH-1:0]      shift_ff, shift_in;
   logic [BCD_WIDTH-1:0]      bcd_ff, bcd_in;
   logic                      neg_ff, neg_in;
   logic [STEP_CNT_WIDTH-1:0] step_ff, step_in;
   logic [LEFT_WIDTH-1:0]     left_ff, left_in;
   logic                      valid_ff, valid_in;
   logic [7:0]                char_ff, char_in;
   logic                      last_ff, last_in;

   logic [WORD_WIDTH-1:0]     word;
   logic                      load_neg;
   logic [WORD_WIDTH-1:0]     mag;
   logic [3:0]                top_digit;
   logic                      out_free;
   logic [PAD_WIDTH-1:0]      conv_sh;
   logic [BCD_WIDTH-1:0]      conv_bcd;

   assign word      = value[WORD_WIDTH-1:0];
   assign load_neg  = is_signed & word[WORD_WIDTH-1];
   assign mag       = load_neg ? (~word + 1'b1) : word;
   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];
   assign out_free  = !valid_ff || out_ready;

   // BITS_PER_STEP rounds of add-3 then shift, MSB first
   always_comb begin
      conv_sh  = shift_ff;
      conv_bcd = bcd_ff;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (conv_bcd[4*d +: 4] >= 4'd5) begin
               conv_bcd[4*d +: 4] = conv_bcd[4*d +: 4] + 4'd3;
            end
         end
         conv_bcd = {conv_bcd[BCD_WIDTH-2:0], conv_sh[PAD_WIDTH-1]};
         conv_sh  = {conv_sh[PAD_WIDTH-2:0], 1'b0};
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.load) begin
         shift_in = PAD_WIDTH'(mag);
         bcd_in   = '0;
         neg_in   = load_neg;
         step_in  = '0;
         left_in  = LEFT_WIDTH'(NUM_DIGITS);
      end
      if (cmd.convert) begin
         shift_in = conv_sh;
         bcd_in   = conv_bcd;
         step_in  = step_ff + 1'b1;
      end
      if (cmd.skip) begin
         bcd_in  = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
         left_in = left_ff - 1'b1;
      end
      if (cmd.emit_sign) begin
         char_in  = CH_MINUS;
         last_in  = 1'b0;
         valid_in = 1'b1;
      end
      if (cmd.emit_digit) begin
         char_in  = CH_ZERO + {4'd0, top_digit};
         last_in  = (left_ff == LEFT_WIDTH'(1));
         valid_in = 1'b1;
         bcd_in   = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
         left_in  = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      neg_ff   <= neg_in;
      step_ff  <= step_in;
      left_ff  <= left_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign status.step_done  = (step_ff == STEP_CNT_WIDTH'(NUM_STEPS - 1));
   assign status.top_zero   = (top_digit == 4'd0);
   assign status.last_digit = (left_ff == LEFT_WIDTH'(1));
   assign status.negative   = neg_ff;
   assign status.out_free   = out_free;

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

>>> src/b2da_ctrl.sv
// ----------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: load, convert, drop leading zeros, emit sign and digits.
// ----------------------------------------------------------------------------
module b2da_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  b2da_pkg::status_type  status,
   output b2da_pkg::cmd_type     cmd
);
   import b2da_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
            if (status.step_done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (status.top_zero && !status.last_digit) begin
               cmd.skip = 1'b1;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/binary_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Converts a 32-bit word, signed or unsigned, to decimal ASCII characters.
// ----------------------------------------------------------------------------
// Each request transaction carries a 32-bit word and a signed flag; the block
// answers with its decimal text, one character per response transaction,
// most significant digit first, with a leading '-' for negative signed words
// and tlast on the final digit. No leading zeros; zero gives "0", and the
// most negative word gives -2147483648. One word is handled at a time: after
// acceptance a shift-add-3 BCD converter takes 4 bits a cycle, the leading
// zeros (10 minus the digit count of them) are then dropped one digit a
// cycle, and characters leave through a single output register at one per
// cycle when the sink is ready. req_tready is high only between words, while
// the last character may still wait in the output register.
module binary_to_decimal_ascii_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tuser,   // [0] is_signed
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] char_code
   output logic        rsp_tlast    // last character of the number
);
   import b2da_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   b2da_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   // conversion datapath and output register
   b2da_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .value     (req_tdata),
      .is_signed (req_tuser),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

>>> src/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module b2da_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   import b2da_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // only '-' or a digit ever leaves
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == CH_MINUS) || (rsp_tdata >= CH_ZERO && rsp_tdata <= CH_NINE))
      else $error("character out of range");

   // the sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == CH_MINUS |-> !rsp_tlast)
      else $error("sign marked last");

   // one word at a time: ready drops after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
